// ===== src/assert_macros.svh =====
// Assertion helpers for the checker in bba_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("assertion failed");

`endif

// ===== src/bba_pkg.sv =====
package bba_pkg;

    localparam int MAX_ORDER   = 10;
    localparam int ORDER_COUNT = MAX_ORDER + 1;
    localparam int POOL_LEN    = 1 << MAX_ORDER;
    localparam int IDX_W       = MAX_ORDER;
    localparam int LINK_W      = MAX_ORDER + 1;
    localparam int ORD_W       = 4;

    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(POOL_LEN);

    localparam logic [1:0] FUNC_ALLOC = 2'd0;
    localparam logic [1:0] FUNC_FREE  = 2'd1;
    localparam logic [1:0] FUNC_INIT  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFREE  = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    typedef struct packed {
        logic [1:0]        func;
        logic [LINK_W-1:0] block_count;
        logic [IDX_W-1:0]  block_index;
    } t_req;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] block_index_res;
    } t_res;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_SEARCH,
        S_POPW,
        S_SPLIT,
        S_REM_INIT,
        S_WALK,
        S_WALKW,
        S_PUSH
    } t_state;

    // Smallest order whose size covers count; ORDER_COUNT when none does.
    function automatic logic [ORD_W-1:0] order_for(input logic [LINK_W-1:0] count);
        logic [ORD_W-1:0] k;
        logic             found;
        k     = ORD_W'(ORDER_COUNT);
        found = 1'b0;
        for (int i = 0; i < ORDER_COUNT; i++) begin
            if (!found && ((LINK_W'(1) << i) >= count)) begin
                k     = ORD_W'(i);
                found = 1'b1;
            end
        end
        return k;
    endfunction

endpackage

// ===== src/bba_link_ram.sv =====
module bba_link_ram (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [bba_pkg::IDX_W-1:0]  i_waddr,
    input  logic [bba_pkg::LINK_W-1:0] i_wdata,
    input  logic [bba_pkg::IDX_W-1:0]  i_raddr,
    output logic [bba_pkg::LINK_W-1:0] o_rdata
);
    import bba_pkg::*;

    logic [LINK_W-1:0] r_mem [0:POOL_LEN-1];
    logic [LINK_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/buddy_block_allocator.sv =====
// Binary buddy allocator, one item at a time; busy is high while an item is at work.
// Initialize carves the pool from order MAX_ORDER down to order 0. Allocate searches orders upward,
// pops a block, then splits it down. Free walks the list of each merge order for the buddy, one link
// RAM read per element, then pushes the merged region. Bad requests are answered straight from idle.
// Reset (synchronous, active low) empties all lists and clears the pool size; no clearing pass.
// The result strobe lasts one cycle; the receiver cannot stall it.
module buddy_block_allocator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  bba_pkg::t_req              i_req,
    output logic                       o_res_valid,
    output bba_pkg::t_res              o_res,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [bba_pkg::LINK_W-1:0] i_cfg_data
);
    import bba_pkg::*;

    // Sequencer and registers
    t_state            r_state, n_state;
    logic [LINK_W-1:0] r_head [0:MAX_ORDER];
    logic [ORD_W-1:0]  r_ord, n_ord;     // order under work
    logic [ORD_W-1:0]  r_want, n_want;   // requested order for allocate
    logic [IDX_W-1:0]  r_blk, n_blk;     // popped block for allocate
    logic [IDX_W-1:0]  r_p, n_p;         // region being freed / merged
    logic [LINK_W-1:0] r_cur, n_cur;     // list walk cursor
    logic [LINK_W-1:0] r_prev, n_prev;
    logic [LINK_W-1:0] r_steps, n_steps; // walk bound
    logic [LINK_W-1:0] r_off, n_off;     // init carve offset
    logic [LINK_W-1:0] r_pool_blocks;
    logic [LINK_W-1:0] r_psize, n_psize;
    logic              r_res_valid, n_res_valid;
    t_res              r_res, n_res;

    // Head list write port
    logic              head_clr_all;
    logic              head_we;
    logic [ORD_W-1:0]  head_widx;
    logic [LINK_W-1:0] head_wdata;

    // Link RAM port
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [LINK_W-1:0] mem_wdata;
    logic [IDX_W-1:0]  mem_raddr;
    logic [LINK_W-1:0] mem_rdata;

    // Shared decode
    logic              acc;
    logic [ORD_W-1:0]  req_ord;
    logic [LINK_W-1:0] req_size;
    logic              alloc_ok;
    logic              free_ok;
    logic [LINK_W-1:0] head_cur;
    logic [LINK_W-1:0] ord_bit;   // 2^r_ord
    logic [LINK_W-1:0] nx_link;
    logic [IDX_W-1:0]  buddy;
    logic              hit;
    logic              walk_end;

    bba_link_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign acc         = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    assign req_ord  = order_for(i_req.block_count);
    assign req_size = LINK_W'(1) << req_ord;
    assign alloc_ok = (i_req.block_count != '0) && (req_ord <= ORD_W'(MAX_ORDER));
    // Free must be aligned to its rounded size and lie inside the pool.
    assign free_ok  = (i_req.block_count != '0) && (i_req.block_count <= r_psize)
                   && (req_ord <= ORD_W'(MAX_ORDER))
                   && ((i_req.block_index & IDX_W'(req_size - LINK_W'(1))) == '0)
                   && ((LINK_W'(i_req.block_index) + req_size) <= r_psize);

    assign head_cur = (r_ord <= ORD_W'(MAX_ORDER)) ? r_head[r_ord] : NIL_LINK;
    assign ord_bit  = LINK_W'(1) << r_ord;
    assign nx_link  = (mem_rdata < NIL_LINK) ? mem_rdata : NIL_LINK;
    assign buddy    = r_p ^ ord_bit[IDX_W-1:0];
    assign hit      = (r_cur == LINK_W'(buddy));
    assign walk_end = (r_steps == LINK_W'(POOL_LEN)) || (r_cur >= NIL_LINK);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (i_req.func == FUNC_INIT) begin
                        n_state = S_INIT;
                    end else if (i_req.func == FUNC_ALLOC && alloc_ok) begin
                        n_state = S_SEARCH;
                    end else if (i_req.func == FUNC_FREE && free_ok) begin
                        n_state = S_REM_INIT;
                    end
                end
            end
            S_INIT: begin
                if (r_ord == '0) n_state = S_IDLE;
            end
            S_SEARCH: begin
                if (r_ord > ORD_W'(MAX_ORDER)) n_state = S_IDLE;
                else if (head_cur < NIL_LINK) n_state = S_POPW;
            end
            S_POPW: begin
                n_state = (r_ord == r_want) ? S_IDLE : S_SPLIT;
            end
            S_SPLIT: begin
                if (r_ord == r_want) n_state = S_IDLE;
            end
            S_REM_INIT: begin
                n_state = (r_ord == ORD_W'(MAX_ORDER)) ? S_PUSH : S_WALK;
            end
            S_WALK: begin
                n_state = walk_end ? S_PUSH : S_WALKW;
            end
            S_WALKW: begin
                n_state = hit ? S_REM_INIT : S_WALK;
            end
            S_PUSH: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        n_ord        = r_ord;
        n_want       = r_want;
        n_blk        = r_blk;
        n_p          = r_p;
        n_cur        = r_cur;
        n_prev       = r_prev;
        n_steps      = r_steps;
        n_off        = r_off;
        n_psize      = r_psize;
        n_res_valid  = 1'b0;
        n_res        = r_res;
        head_clr_all = 1'b0;
        head_we      = 1'b0;
        head_widx    = r_ord;
        head_wdata   = NIL_LINK;
        mem_we       = 1'b0;
        mem_waddr    = r_p;
        mem_wdata    = head_cur;
        mem_raddr    = r_cur[IDX_W-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (i_req.func == FUNC_INIT) begin
                        n_psize = (r_pool_blocks > LINK_W'(POOL_LEN)) ?
                                  LINK_W'(POOL_LEN) : r_pool_blocks;
                        head_clr_all = 1'b1;
                        n_ord = ORD_W'(MAX_ORDER);
                        n_off = '0;
                    end else if (i_req.func == FUNC_ALLOC && alloc_ok) begin
                        n_ord  = req_ord;
                        n_want = req_ord;
                    end else if (i_req.func == FUNC_FREE && free_ok) begin
                        n_ord = req_ord;
                        n_p   = i_req.block_index;
                    end else begin
                        n_res_valid = 1'b1;
                        n_res       = '{status: ST_INVALID, block_index_res: '0};
                    end
                end
            end
            S_INIT: begin
                // carve the pool high order first; lists are empty here
                if (r_psize[r_ord]) begin
                    mem_we     = 1'b1;
                    mem_waddr  = r_off[IDX_W-1:0];
                    mem_wdata  = NIL_LINK;
                    head_we    = 1'b1;
                    head_wdata = r_off;
                    n_off      = r_off + ord_bit;
                end
                if (r_ord == '0) begin
                    n_res_valid = 1'b1;
                    n_res       = '{status: ST_OK, block_index_res: '0};
                end else begin
                    n_ord = r_ord - ORD_W'(1);
                end
            end
            S_SEARCH: begin
                if (r_ord > ORD_W'(MAX_ORDER)) begin
                    n_res_valid = 1'b1;
                    n_res       = '{status: ST_NOFREE, block_index_res: '0};
                end else if (head_cur < NIL_LINK) begin
                    n_blk     = head_cur[IDX_W-1:0];
                    mem_raddr = head_cur[IDX_W-1:0];
                end else begin
                    n_ord = r_ord + ORD_W'(1);
                end
            end
            S_POPW: begin
                head_we    = 1'b1;
                head_wdata = nx_link;
                if (r_ord == r_want) begin
                    n_res_valid = 1'b1;
                    n_res       = '{status: ST_OK, block_index_res: r_blk};
                end else begin
                    n_ord = r_ord - ORD_W'(1);
                end
            end
            S_SPLIT: begin
                // upper half of the current split goes on list r_ord
                mem_we     = 1'b1;
                mem_waddr  = r_blk + ord_bit[IDX_W-1:0];
                mem_wdata  = head_cur;
                head_we    = 1'b1;
                head_wdata = LINK_W'(r_blk + ord_bit[IDX_W-1:0]);
                if (r_ord == r_want) begin
                    n_res_valid = 1'b1;
                    n_res       = '{status: ST_OK, block_index_res: r_blk};
                end else begin
                    n_ord = r_ord - ORD_W'(1);
                end
            end
            S_REM_INIT: begin
                n_cur   = head_cur;
                n_prev  = NIL_LINK;
                n_steps = '0;
            end
            S_WALK: begin
                mem_raddr = r_cur[IDX_W-1:0];
            end
            S_WALKW: begin
                if (hit) begin
                    // unlink the buddy and merge one order up
                    if (r_prev == NIL_LINK) begin
                        head_we    = 1'b1;
                        head_wdata = nx_link;
                    end else begin
                        mem_we    = 1'b1;
                        mem_waddr = r_prev[IDX_W-1:0];
                        mem_wdata = nx_link;
                    end
                    n_p   = r_p & ~ord_bit[IDX_W-1:0];
                    n_ord = r_ord + ORD_W'(1);
                end else begin
                    n_prev  = r_cur;
                    n_cur   = nx_link;
                    n_steps = r_steps + LINK_W'(1);
                end
            end
            S_PUSH: begin
                mem_we      = 1'b1;
                mem_waddr   = r_p;
                mem_wdata   = head_cur;
                head_we     = 1'b1;
                head_wdata  = LINK_W'(r_p);
                n_res_valid = 1'b1;
                n_res       = '{status: ST_OK, block_index_res: '0};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_res_valid   <= 1'b0;
            r_pool_blocks <= LINK_W'(POOL_LEN);
            r_psize       <= '0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
            r_psize     <= n_psize;
            if (i_cfg_valid && o_cfg_ready) begin
                r_pool_blocks <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ORDER_COUNT; i++) r_head[i] <= NIL_LINK;
        end else if (head_clr_all) begin
            for (int i = 0; i < ORDER_COUNT; i++) r_head[i] <= NIL_LINK;
        end else if (head_we) begin
            r_head[head_widx] <= head_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ord   <= n_ord;
        r_want  <= n_want;
        r_blk   <= n_blk;
        r_p     <= n_p;
        r_cur   <= n_cur;
        r_prev  <= n_prev;
        r_steps <= n_steps;
        r_off   <= n_off;
        r_res   <= n_res;
    end

endmodule

// ===== src/bba_checker.sv =====
`include "assert_macros.svh"

module bba_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       o_res_valid,
    input bba_pkg::t_res              o_res
);
    import bba_pkg::*;

    // an accepted item either starts work or answers at once
    `ASSERT_NEXT(a_accept_progress, i_clk, i_rst_n, start && !busy, busy || o_res_valid)
    // failed requests never carry a block index
    `ASSERT_IMPL(a_fail_zero_idx, i_clk, i_rst_n, o_res_valid && o_res.status != ST_OK, o_res.block_index_res == '0)
    // a result only follows work or an accepted item
    `ASSERT_IMPL(a_res_has_cause, i_clk, i_rst_n, o_res_valid, $past(busy) || $past(start))

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_res_valid (o_res_valid),
    .o_res       (o_res)
);

// ===== test/tb_buddy_block_allocator.sv =====
`default_nettype none

module tb_buddy_block_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    import bba_pkg::*;

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // DUT
    // ------------------------------------------------------------------
    logic              start = 1'b0;
    logic              busy;
    t_req              i_req = '0;
    logic              o_res_valid;
    t_res              o_res;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [LINK_W-1:0] i_cfg_data = '0;

    buddy_block_allocator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_res_valid(o_res_valid),
        .o_res      (o_res),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Shadow allocator state: list heads, per-block links, pool size
    // and the pool_blocks register. Links are only read for blocks on a
    // list, so their initial content does not matter.
    // ------------------------------------------------------------------
    int unsigned free_head [ORDER_COUNT];
    int unsigned next_link [POOL_LEN];
    int unsigned pool_reg  = 1024;
    int unsigned pool_size = 0;

    typedef struct {
        t_req req;
        t_res res;
    } t_pending;

    typedef struct {
        int unsigned base;
        int unsigned ord;
    } t_region;

    t_req     item_q[$];     // items waiting for the driver
    t_pending result_q[$];   // predicted results, oldest first
    t_region  live_q[$];     // regions currently handed out by the allocator

    int errors = 0;
    int n_accepted = 0;
    int n_alloc_ok = 0;
    int n_nofree = 0;
    int n_free_ok = 0;
    int n_invalid = 0;
    int n_cfg = 0;
    bit quiet = 1'b0;        // no idle bursts when set

    function automatic int unsigned order_of(int unsigned count);
        for (int k = 0; k <= MAX_ORDER; k++)
            if ((1 << k) >= count) return k;
        return ORDER_COUNT;
    endfunction

    function automatic void list_push(int unsigned blk, int unsigned ord);
        blk = blk & (POOL_LEN - 1);
        next_link[blk] = free_head[ord];
        free_head[ord] = blk;
    endfunction

    function automatic int unsigned list_pop(int unsigned ord);
        int unsigned blk;
        int unsigned nx;
        blk = free_head[ord];
        nx  = next_link[blk & (POOL_LEN - 1)];
        free_head[ord] = (nx < POOL_LEN) ? nx : POOL_LEN;
        return blk;
    endfunction

    // Unlink target from list ord; walk bounded like the hardware's.
    function automatic bit list_unlink(int unsigned ord, int unsigned target);
        int unsigned prev;
        int unsigned cur;
        int unsigned nx;
        prev = POOL_LEN;
        cur  = free_head[ord];
        for (int s = 0; s < POOL_LEN && cur < POOL_LEN; s++) begin
            nx = next_link[cur];
            if (nx >= POOL_LEN) nx = POOL_LEN;
            if (cur == target) begin
                if (prev == POOL_LEN) free_head[ord] = nx;
                else next_link[prev] = nx;
                return 1'b1;
            end
            prev = cur;
            cur  = nx;
        end
        return 1'b0;
    endfunction

    // Apply one item to the shadow state and return the answer it gives.
    function automatic t_res allocator_step(t_req r);
        t_res        a;
        int unsigned count;
        int unsigned idx;
        int unsigned want;
        int unsigned k;
        int unsigned p;
        int unsigned blk;
        int unsigned off;
        count = r.block_count;
        idx   = r.block_index;
        a.status = ST_INVALID;
        a.block_index_res = '0;
        case (r.func)
            FUNC_INIT: begin
                pool_size = (pool_reg > POOL_LEN) ? POOL_LEN : pool_reg;
                foreach (free_head[i]) free_head[i] = POOL_LEN;
                off = 0;
                for (int j = MAX_ORDER; j >= 0; j--) begin
                    if (pool_size & (1 << j)) begin
                        list_push(off, j);
                        off += 1 << j;
                    end
                end
                a.status = ST_OK;
            end
            FUNC_ALLOC: begin
                want = order_of(count);
                if (count != 0 && want <= MAX_ORDER) begin
                    a.status = ST_NOFREE;
                    for (int i = want; i <= MAX_ORDER; i++) begin
                        if (free_head[i] < POOL_LEN) begin
                            blk = list_pop(i);
                            // split down, upper halves go back on their lists
                            for (int j = i; j > want; j--)
                                list_push(blk + (1 << (j - 1)), j - 1);
                            a.status = ST_OK;
                            a.block_index_res = blk[IDX_W-1:0];
                            break;
                        end
                    end
                end
            end
            FUNC_FREE: begin
                if (count != 0 && count <= pool_size) begin
                    k = order_of(count);
                    if (k <= MAX_ORDER && (idx & ((1 << k) - 1)) == 0
                            && idx + (1 << k) <= pool_size) begin
                        p = idx;
                        // coalesce while the buddy is free at the same order
                        while (k < MAX_ORDER) begin
                            if (!list_unlink(k, p ^ (1 << k))) break;
                            p = p & ~(1 << k);
                            k++;
                        end
                        list_push(p, k);
                        a.status = ST_OK;
                    end
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // ------------------------------------------------------------------
    // Driver: presents queued items on start, with random idle bursts.
    // accepted marks that the item on the port was taken at the last edge.
    // ------------------------------------------------------------------
    bit accepted = 1'b0;
    int gap = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || accepted) begin
            if (gap > 0) begin
                gap   <= gap - 1;
                start <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                gap   <= $urandom_range(0, 4);
                start <= 1'b0;
            end else if (item_q.size() > 0) begin
                i_req <= item_q.pop_front();
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
        accepted = 1'b0;
    end

    // ------------------------------------------------------------------
    // Monitor: check the strobed result against the oldest prediction,
    // then predict for an item accepted at this edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_pending pend;
        t_region  reg_live;
        if (i_rst_n) begin
            if (o_res_valid) begin
                if (result_q.size() == 0) begin
                    report("unexpected result", o_res.status, -1);
                end else begin
                    pend = result_q.pop_front();
                    if (o_res.status !== pend.res.status)
                        report("status", o_res.status, pend.res.status);
                    if (o_res.block_index_res !== pend.res.block_index_res)
                        report("block_index_res", o_res.block_index_res,
                               pend.res.block_index_res);
                    case (pend.res.status)
                        ST_NOFREE:  n_nofree++;
                        ST_INVALID: n_invalid++;
                        default: ;
                    endcase
                    if (pend.res.status == ST_OK) begin
                        if (pend.req.func == FUNC_ALLOC) begin
                            reg_live.base = pend.res.block_index_res;
                            reg_live.ord  = order_of(pend.req.block_count);
                            live_q.push_back(reg_live);
                            n_alloc_ok++;
                        end else if (pend.req.func == FUNC_FREE) begin
                            n_free_ok++;
                        end else begin
                            live_q.delete();
                        end
                    end
                end
            end
            if (start && !busy) begin
                pend.req = i_req;
                pend.res = allocator_step(i_req);
                result_q.push_back(pend);
                n_accepted++;
                accepted = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic add(logic [1:0] f, int unsigned count, int unsigned idx);
        t_req r;
        r.func        = f;
        r.block_count = count[LINK_W-1:0];
        r.block_index = idx[IDX_W-1:0];
        item_q.push_back(r);
    endtask

    // Sender holds off until every outstanding item has answered.
    // Rechecked after the edge: an item popped at the falling edge raises
    // start only once the driver's update lands.
    task automatic drain();
        do begin
            wait (item_q.size() == 0 && result_q.size() == 0 && !start);
            @(posedge i_clk);
        end while (!(item_q.size() == 0 && result_q.size() == 0 && !start));
    endtask

    task automatic write_pool(int unsigned val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= val[LINK_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        pool_reg = val & 11'h7FF;
        n_cfg++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly small requests, now and then a big one.
    function automatic int unsigned rand_count();
        int unsigned sh;
        sh = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_ORDER)
                                          : $urandom_range(0, 4);
        return $urandom_range(1, 1 << sh);
    endfunction

    // Free a region from the live set, with a count that rounds to its order.
    task automatic free_live();
        int      pick;
        t_region rg;
        int unsigned cnt;
        pick = $urandom_range(0, live_q.size() - 1);
        rg   = live_q[pick];
        live_q.delete(pick);
        cnt  = (rg.ord == 0) ? 1 : $urandom_range((1 << (rg.ord - 1)) + 1, 1 << rg.ord);
        add(FUNC_FREE, cnt, rg.base);
    endtask

    task automatic noise();
        add($urandom_range(0, 3), $urandom_range(0, 2047), $urandom_range(0, 1023));
    endtask

    // One round: a batch of allocations, wait, then frees mixed with
    // allocations and a little noise.
    task automatic round();
        int n;
        n = $urandom_range(4, 12);
        repeat (n) add(FUNC_ALLOC, rand_count(), 0);
        drain();
        n = $urandom_range(4, 12);
        repeat (n) begin
            case ($urandom_range(0, 9))
                0:       noise();
                1, 2:    add(FUNC_ALLOC, rand_count(), 0);
                default: if (live_q.size() > 0) free_live(); else noise();
            endcase
        end
        drain();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    int unsigned pools[] = '{1, 1000, 0, 2047, 37, 512, 1023};

    initial begin
        foreach (free_head[i]) free_head[i] = POOL_LEN;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: behavior before any pool exists, then the edges.
        add(FUNC_ALLOC, 1, 0);          // no pool yet: no free block
        add(FUNC_FREE, 1, 0);           // no pool yet: invalid
        add(2'd3, 5, 7);                // unused function code
        add(FUNC_INIT, 0, 0);           // pool of 1024 at reset value
        add(FUNC_ALLOC, 0, 0);          // zero count
        add(FUNC_ALLOC, 1025, 0);       // too large
        add(FUNC_ALLOC, 2047, 1023);
        add(FUNC_ALLOC, 1, 0);          // splits the whole pool down
        add(FUNC_ALLOC, 1024, 0);       // nothing that big left
        add(FUNC_ALLOC, 3, 0);
        add(FUNC_FREE, 2, 1);           // misaligned
        add(FUNC_FREE, 1025, 0);        // beyond pool
        add(FUNC_FREE, 0, 0);           // zero count
        add(FUNC_FREE, 1, 0);
        add(FUNC_FREE, 4, 4);           // merge chain
        add(FUNC_FREE, 1, 0);           // double free, not detected
        add(FUNC_ALLOC, 512, 0);
        add(FUNC_FREE, 512, 512);       // frees a region that was never handed out
        add(FUNC_FREE, 1, 1023);
        add(FUNC_INIT, 0, 0);
        add(FUNC_ALLOC, 1024, 0);
        add(FUNC_FREE, 1024, 0);
        drain();

        // Random rounds across pool sizes, the extremes among them.
        foreach (pools[p]) begin
            write_pool(pools[p]);
            add(FUNC_INIT, 0, 0);
            drain();
            repeat (3) round();
        end
        write_pool($urandom_range(2, 1023));
        add(FUNC_INIT, 0, 0);
        drain();
        while (n_accepted < 420) round();

        // Last stretch without any idling, pool back at full size.
        quiet = 1'b1;
        write_pool(1024);
        add(FUNC_INIT, 0, 0);
        drain();
        while (n_accepted < 450) round();

        drain();
        repeat (30) @(posedge i_clk);
        $display("%0d items: %0d allocs ok, %0d refused, %0d frees ok, %0d invalid",
                 n_accepted, n_alloc_ok, n_nofree, n_free_ok, n_invalid);
        $display("%0d pool size writes incl. 0, 1, 1024 and 2047", n_cfg);
        if (errors == 0 && result_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest run of free walks.
    initial begin
        #500ms;
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+src
src/bba_pkg.sv
src/bba_link_ram.sv
src/buddy_block_allocator.sv
src/bba_checker.sv
test/tb_buddy_block_allocator.sv
